// ----- hw/rtl/clsrng_pkg.sv -----
// ============================================================================
// clsrng_pkg: shared definitions for the combined LCG shuffle generator
// Table geometry, generator constants, generator select and sequencer states.
// ============================================================================
package clsrng_pkg;

   // Shuffle table geometry.
   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);

   // Word widths. Seeds and the second generator can carry 2^31 after a
   // reseed of the most negative seed, so they take 32 bits.
   localparam int WORD_W = 31;
   localparam int SEED_W = 32;
   localparam int MUL_W  = 16;
   localparam int FOLD_W = 8;
   localparam int PROD_W = MUL_W + SEED_W;
   localparam int HI_W   = PROD_W - WORD_W;
   localparam int HIF_W  = HI_W + FOLD_W;

   // Warm-up length after a reseed.
   localparam int WARM_STEPS = TABLE_DEPTH + 8;
   localparam int WCNT_W     = $clog2(WARM_STEPS);

   // Generator constants. FOLD is 2^31 mod the modulus.
   localparam logic [SEED_W-1:0] MOD1 = 32'd2147483563;
   localparam logic [SEED_W-1:0] MOD2 = 32'd2147483399;
   localparam logic [MUL_W-1:0]  MUL1 = 16'd40014;
   localparam logic [MUL_W-1:0]  MUL2 = 16'd40692;
   localparam logic [FOLD_W-1:0] FOLD1 = 8'd85;
   localparam logic [FOLD_W-1:0] FOLD2 = 8'd249;
   localparam logic [SEED_W-1:0] SECOND_RESET = 32'd123456789;

   // Slot divisor: 1 + (MOD1 - 1) / TABLE_DEPTH.
   localparam longint SLOT_DIV_L = 64'd1 + (64'd2147483562 / TABLE_DEPTH);

   typedef enum logic {
      GEN_FIRST,
      GEN_SECOND
   } gen_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WARM_ISSUE,
      ST_WARM_WAIT,
      ST_DRAW,
      ST_DIVIDE,
      ST_READ,
      ST_MIX,
      ST_DELIVER
   } state_type;

endpackage

// ----- hw/rtl/clsrng_modmul.sv -----
// ============================================================================
// clsrng_modmul: pipelined modular multiply for one LCG step
// Computes (MUL * z) mod M for z up to 2^31, with product and sum registered.
// ============================================================================
module clsrng_modmul import clsrng_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  gen_sel_type       sel,
   input  logic              in_valid,
   input  logic [SEED_W-1:0] in_word,
   output logic              out_valid,
   output logic [WORD_W-1:0] out_word
);

   logic [MUL_W-1:0]  mul_c;
   logic [FOLD_W-1:0] fold_c;
   logic [SEED_W-1:0] mod_c;

   logic              v1_ff, v1_in, v2_ff, v2_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [SEED_W-1:0] sum_ff, sum_in;
   logic [HIF_W-1:0]  hi_fold;
   logic [SEED_W-1:0] diff;

   always_comb begin
      unique case (sel)
         GEN_FIRST: begin
            mul_c  = MUL1;
            fold_c = FOLD1;
            mod_c  = MOD1;
         end
         GEN_SECOND: begin
            mul_c  = MUL2;
            fold_c = FOLD2;
            mod_c  = MOD2;
         end
         default: begin
            mul_c  = MUL1;
            fold_c = FOLD1;
            mod_c  = MOD1;
         end
      endcase
   end

   // Stage one: full product. Stage two: fold the bits above 2^31 back in,
   // since 2^31 is congruent to FOLD. The folded sum stays below twice the
   // modulus, so a single conditional subtract finishes the reduction.
   assign prod_in = {{SEED_W{1'b0}}, mul_c} * {{MUL_W{1'b0}}, in_word};
   assign hi_fold = {{FOLD_W{1'b0}}, prod_ff[PROD_W-1:WORD_W]} *
                    {{HI_W{1'b0}}, fold_c};
   assign sum_in  = {1'b0, prod_ff[WORD_W-1:0]} + SEED_W'(hi_fold);
   assign v1_in   = in_valid;
   assign v2_in   = v1_ff;
   assign diff    = sum_ff - mod_c;

   assign out_valid = v2_ff;
   assign out_word  = (sum_ff >= mod_c) ? diff[WORD_W-1:0] : sum_ff[WORD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

endmodule

// ----- hw/rtl/combined_lcg_shuffle_rng.sv -----
// ============================================================================
// combined_lcg_shuffle_rng: combined LCG with a shuffle table
// Two modular LCGs are combined through a shuffle table held in a RAM.
// ============================================================================
//
//  Channel | Direction | Payload                          | Handshake
//  --------+-----------+----------------------------------+----------------------
//  req     | in        | tdata[31:0]  seed_in (signed)    | tvalid / tready
//  rsp     | out       | tdata[30:0]  seed_out,           | tvalid / tready
//          |           | tdata[61:31] variate, rest zero  |
//
// After the idle state takes the request, a draw launches both LCG steps,
// then picks the table slot by comparing the last variate against the slot
// boundaries, then reads the RAM while the LCG steps finish, then forms the
// mix, and finally loads the result register.
// A reseed (seed zero or negative) first runs 40 dependent steps of the first
// generator through the two-stage multiplier.
// Reset is synchronous; it clears the sequencer, the result valid flag and
// the per-entry valid bits of the table, so unwritten entries read as zero.
// A new request is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register; a stalled output holds
// the sequencer in its last state until the result register frees up.
//
module combined_lcg_shuffle_rng import clsrng_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] seed_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata     // [30:0] seed_out, [61:31] variate
);

   // Sequencer.
   state_type state_ff, state_in;

   // Generator words and history.
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [SEED_W-1:0] second_ff, second_in;
   logic [WORD_W-1:0] last_ff, last_in;
   logic [WCNT_W-1:0] warm_cnt_ff, warm_cnt_in;

   // Slot selection.
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [IDX_W-1:0]  slot_pick;

   // Mix and result register.
   logic [WORD_W-1:0] mix_ff, mix_in;
   logic [SEED_W:0]   mix_raw;
   logic [SEED_W:0]   mix_adj;
   logic [WORD_W-1:0] entry;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_seed_ff, rsp_seed_in;
   logic [WORD_W-1:0] rsp_var_ff, rsp_var_in;

   // Shuffle table RAM and its valid bits.
   logic [WORD_W-1:0]      table_mem [TABLE_DEPTH];
   logic [WORD_W-1:0]      rd_data_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   logic [WORD_W-1:0]      mem_wd;

   // Control strobes.
   logic              req_fire;
   logic              reseed;
   logic [SEED_W-1:0] magnitude;
   logic              mm1_start, mm2_start;
   logic              mm1_done, mm2_done;
   logic [WORD_W-1:0] mm1_word, mm2_word;
   logic              rsp_load;
   logic              warm_in_table;

   clsrng_modmul u_first (
      .clock     (clock),
      .reset     (reset),
      .sel       (GEN_FIRST),
      .in_valid  (mm1_start),
      .in_word   (seed_ff),
      .out_valid (mm1_done),
      .out_word  (mm1_word)
   );

   clsrng_modmul u_second (
      .clock     (clock),
      .reset     (reset),
      .sel       (GEN_SECOND),
      .in_valid  (mm2_start),
      .in_word   (second_ff),
      .out_valid (mm2_done),
      .out_word  (mm2_word)
   );

   // A zero or negative seed asks for a reseed. The magnitude of the most
   // negative seed is 2^31, which the 32-bit word carries unchanged.
   assign req_fire  = req_tvalid && req_tready;
   assign reseed    = req_tdata[31] || (req_tdata == 32'd0);
   assign magnitude = (req_tdata == 32'd0) ? 32'd1 : (32'd0 - req_tdata);

   assign warm_in_table = (warm_cnt_ff < WCNT_W'(TABLE_DEPTH));

   // The slot is the last variate divided by the slot divisor. The quotient
   // is the number of slot boundaries (multiples of the divisor) that the
   // variate reaches; the comparisons run in parallel against constants.
   // The largest boundary is TABLE_DEPTH-1 divisors, so the slot can never
   // pass the top entry.
   always_comb begin
      slot_pick = '0;
      for (int k = 1; k < TABLE_DEPTH; k++) begin
         if (last_ff >= WORD_W'(longint'(k) * SLOT_DIV_L)) begin
            slot_pick = IDX_W'(k);
         end
      end
   end

   // Entries never written since reset read as zero.
   assign entry   = valid_ff[slot_ff] ? rd_data_ff : '0;
   assign mix_raw = {2'b00, entry} - {1'b0, second_ff};
   assign mix_adj = (mix_raw[SEED_W] || (mix_raw == '0)) ?
                    (mix_raw + {1'b0, MOD1} - 33'd1) : mix_raw;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = reseed ? ST_WARM_ISSUE : ST_DRAW;
            end
         end
         ST_WARM_ISSUE: begin
            state_in = ST_WARM_WAIT;
         end
         ST_WARM_WAIT: begin
            if (mm1_done) begin
               state_in = (warm_cnt_ff == '0) ? ST_DRAW : ST_WARM_ISSUE;
            end
         end
         ST_DRAW: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      mm1_start  = 1'b0;
      mm2_start  = 1'b0;
      mem_we     = 1'b0;
      mem_wa     = slot_ff;
      mem_wd     = seed_ff[WORD_W-1:0];
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_WARM_ISSUE: begin
            mm1_start = 1'b1;
         end
         ST_WARM_WAIT: begin
            // The last TABLE_DEPTH warm-up words fill the table from the top
            // entry down to entry zero.
            mem_we = mm1_done && warm_in_table;
            mem_wa = warm_cnt_ff[IDX_W-1:0];
            mem_wd = mm1_word;
         end
         ST_DRAW: begin
            mm1_start = 1'b1;
            mm2_start = 1'b1;
         end
         ST_DIVIDE, ST_READ: begin
         end
         ST_MIX: begin
            // The chosen slot takes the new first-generator word.
            mem_we = 1'b1;
         end
         ST_DELIVER: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      seed_in      = seed_ff;
      second_in    = second_ff;
      last_in      = last_ff;
      warm_cnt_in  = warm_cnt_ff;
      slot_in      = slot_ff;
      mix_in       = mix_ff;
      valid_in     = valid_ff;
      rsp_seed_in  = rsp_seed_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (req_fire) begin
         if (reseed) begin
            seed_in     = magnitude;
            second_in   = magnitude;
            warm_cnt_in = WCNT_W'(WARM_STEPS - 1);
         end else begin
            seed_in = req_tdata;
         end
      end

      if (mm1_done) begin
         seed_in = {1'b0, mm1_word};
         if (state_ff == ST_WARM_WAIT) begin
            warm_cnt_in = warm_cnt_ff - WCNT_W'(1);
            if (warm_cnt_ff == '0) begin
               last_in = mm1_word;
            end
         end
      end

      if (mm2_done) begin
         second_in = {1'b0, mm2_word};
      end

      if (state_ff == ST_DIVIDE) begin
         slot_in = slot_pick;
      end

      if (state_ff == ST_MIX) begin
         mix_in  = mix_adj[WORD_W-1:0];
         last_in = mix_adj[WORD_W-1:0];
      end

      if (mem_we) begin
         valid_in[mem_wa] = 1'b1;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_seed_in  = seed_ff[WORD_W-1:0];
         rsp_var_in   = mix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         second_ff    <= SECOND_RESET;
         last_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         last_ff      <= last_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff     <= seed_in;
      warm_cnt_ff <= warm_cnt_in;
      slot_ff     <= slot_in;
      mix_ff      <= mix_in;
      rsp_seed_ff <= rsp_seed_in;
      rsp_var_ff  <= rsp_var_in;
   end

   // Shuffle table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem[slot_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_var_ff, rsp_seed_ff};

endmodule

// ----- test/combined_lcg_shuffle_rng_tb.sv -----
// ============================================================================
// combined_lcg_shuffle_rng_tb: self-checking bench for the shuffled LCG pair
// Sends seed words on the request stream, predicts each draw with a local
// model of both generators and the shuffle table, and compares every result
// transaction against the oldest prediction, under random flow control.
// ============================================================================
`timescale 1ns / 100ps

module combined_lcg_shuffle_rng_tb;
   import clsrng_pkg::*;

   // Generator constants, kept local so the prediction does not lean on the
   // design's own definitions. Q and R are the Schrage quotient and remainder.
   localparam longint MOD_A    = 64'd2147483563;
   localparam longint MOD_B    = 64'd2147483399;
   localparam longint MUL_A    = 64'd40014;
   localparam longint MUL_B    = 64'd40692;
   localparam longint QUO_A    = 64'd53668;
   localparam longint QUO_B    = 64'd52774;
   localparam longint REM_A    = 64'd12211;
   localparam longint REM_B    = 64'd3791;
   localparam longint B_START  = 64'd123456789;
   localparam int     WARMUP   = TABLE_DEPTH + 8;
   localparam longint SLOT_DIVISOR = 64'd1 + (MOD_A - 64'd1) / TABLE_DEPTH;

   localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [31:0] MOST_POSITIVE = 32'h7FFF_FFFF;
   localparam logic [31:0] MINUS_ONE     = 32'hFFFF_FFFF;

   localparam int RANDOM_ITEMS = 1900;
   localparam int MAX_WAIT     = 17;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int SETTLE       = 150;

   typedef struct packed {
      logic [30:0] seed_out;
      logic [30:0] variate;
   } draw_type;

   // Bench-driven inputs start at known values before the first edge.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] seed_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [30:0] seed_out, [61:31] variate

   // Predicted generator state: second generator, last variate and the table.
   longint second_word;
   longint last_variate;
   longint shuffle_words [TABLE_DEPTH];

   draw_type pending_draws [$];
   logic [31:0] chain_seed;
   bit     send_gaps_on;
   bit     recv_stalls_on;
   int     error_count;
   int     items_sent;
   int     reseed_count;
   int     results_checked;

   combined_lcg_shuffle_rng dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Hard stop in case the design hangs. The slowest correct run stays well
   // below a fifth of this.
   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // One generator step, (mul * z) mod m, in Schrage form. Exact for any
   // z up to 2^31, which covers the magnitude of the most negative seed.
   function automatic longint schrage_step(input longint z, input longint mul,
                                           input longint quo, input longint rem,
                                           input longint m);
      longint k;
      longint v;
      k = z / quo;
      v = mul * (z - k * quo) - k * rem;
      if (v < 0)
         v += m;
      return v;
   endfunction

   // Works out the draw caused by one seed word and advances the predicted
   // state. A zero or negative seed first reseeds and refills the table.
   function automatic draw_type predict_draw(input logic [31:0] seed_word);
      longint   word;
      longint   slot;
      longint   mix;
      draw_type d;
      word = longint'(signed'(seed_word));
      if (word <= 0) begin
         word = -word;
         if (word < 1)
            word = 1;
         second_word = word;
         // The first eight warm-up steps are thrown away; the rest fill the
         // table from the top entry down.
         for (int w = WARMUP - 1; w >= 0; w--) begin
            word = schrage_step(word, MUL_A, QUO_A, REM_A, MOD_A);
            if (w < TABLE_DEPTH)
               shuffle_words[w] = word;
         end
         last_variate = shuffle_words[0];
         reseed_count++;
      end
      word        = schrage_step(word, MUL_A, QUO_A, REM_A, MOD_A);
      second_word = schrage_step(second_word, MUL_B, QUO_B, REM_B, MOD_B);
      slot = last_variate / SLOT_DIVISOR;
      if (slot < 0)
         slot = 0;
      if (slot > TABLE_DEPTH - 1)
         slot = TABLE_DEPTH - 1;
      mix = shuffle_words[int'(slot)] - second_word;
      shuffle_words[int'(slot)] = word;
      if (mix < 1)
         mix += MOD_A - 1;
      last_variate = mix;
      d.seed_out = word[30:0];
      d.variate  = mix[30:0];
      return d;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offers one seed word and waits for its transaction. Valid is only lowered
   // when a gap is drawn, so back-to-back transactions keep it high without a
   // drop within the same time step. The prediction is queued at acceptance,
   // and the predicted seed is kept as the next word of a caller's chain.
   task automatic send_seed(input logic [31:0] seed_word);
      int       gap;
      draw_type d;
      gap = send_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= seed_word;
      do @(posedge clock); while (req_tready !== 1'b1);
      d = predict_draw(seed_word);
      pending_draws.push_back(d);
      chain_seed = {1'b0, d.seed_out};
      items_sent++;
   endtask

   // -------------------------------------------------------------------------
   // Result side
   // -------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [30:0] got,
                                  input logic [30:0] want);
      $display("ERROR at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Draws a stall before each result, then takes one result transaction and
   // checks it against the oldest prediction. Values are read at the edge of
   // the transaction, before the design updates them.
   initial begin : result_checker
      int       stall;
      draw_type want;
      wait (reset == 1'b0);
      forever begin
         stall = recv_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         results_checked++;
         if (pending_draws.size() == 0) begin
            $display("ERROR at %0t ns: result transaction with no request pending",
                     $time);
            error_count++;
         end else begin
            want = pending_draws.pop_front();
            if (rsp_tdata[30:0] !== want.seed_out)
               report_mismatch("seed_out", rsp_tdata[30:0], want.seed_out);
            if (rsp_tdata[61:31] !== want.variate)
               report_mismatch("variate", rsp_tdata[61:31], want.variate);
         end
      end
   end

   // Picks one of four flow-control patterns: none, sender gaps only,
   // receiver stalls only, or both.
   task automatic pick_pacing();
      int mode;
      mode = $urandom_range(0, 3);
      send_gaps_on   = mode[0];
      recv_stalls_on = mode[1];
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Draws before any reseed run against the all-zero table. A seed equal to
   // the first modulus steps to zero, and seeds at or above it get reduced.
   task automatic test_unseeded_draws();
      send_seed(32'd1);
      send_seed(MOST_POSITIVE);
      send_seed(MOD_A[31:0]);
      send_seed(MOD_A[31:0] - 32'd1);
   endtask

   // Seed zero reseeds with one; the most negative seed reseeds with 2^31;
   // minus one and the most negative plus one cover the other ends.
   task automatic test_reseed_extremes();
      send_seed(32'd0);
      send_seed(chain_seed);
      send_seed(chain_seed);
      send_seed(MOST_NEGATIVE);
      send_seed(chain_seed);
      send_seed(chain_seed);
      send_seed(MINUS_ONE);
      send_seed(chain_seed);
      send_seed(MOST_NEGATIVE + 32'd1);
      send_seed(chain_seed);
   endtask

   // After seeding, a seed that steps to zero hands back zero, which the
   // caller then passes in as a reseed request.
   task automatic test_zero_step_after_seeding();
      send_seed(MOD_A[31:0]);
      send_seed(chain_seed);
      send_seed(chain_seed);
      send_seed(MOST_POSITIVE);
   endtask

   // Most traffic is callers' chains: a reseed followed by the returned seed
   // fed back in. About one item in ten is a random word instead, which may
   // break the chain with an early reseed or an out-of-range positive seed.
   task automatic test_random_chains();
      int count;
      int chain_len;
      int pick;
      count = 0;
      while (count < RANDOM_ITEMS) begin
         pick_pacing();
         pick = $urandom_range(0, 19);
         if (pick == 0)
            send_seed(32'd0);
         else if (pick == 1)
            send_seed(MOST_NEGATIVE);
         else
            send_seed($urandom() | MOST_NEGATIVE);
         count++;
         chain_len = $urandom_range(4, 40);
         for (int i = 0; i < chain_len && count < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_seed($urandom());
            else
               send_seed(chain_seed);
            count++;
         end
      end
   endtask

   // Lets every outstanding result come back, then keeps the result checker
   // running before the final check in case the design sends anything unasked.
   task automatic drain_results();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_draws.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE) @(posedge clock);
      if (pending_draws.size() != 0) begin
         $display("ERROR: %0d predicted results never arrived", pending_draws.size());
         error_count++;
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      second_word  = B_START;
      last_variate = 0;
      foreach (shuffle_words[i])
         shuffle_words[i] = 0;
      chain_seed      = 32'd1;
      send_gaps_on    = 1'b1;
      recv_stalls_on  = 1'b1;
      error_count     = 0;
      items_sent      = 0;
      reseed_count    = 0;
      results_checked = 0;

      // Single synchronous reset at the start of the run.
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unseeded_draws();
      test_reseed_extremes();
      test_zero_step_after_seeding();
      test_random_chains();
      drain_results();

      $display("Sent %0d seed transactions, %0d of them reseeds; checked %0d results.",
               items_sent, reseed_count, results_checked);
      $display("Stimulus mixed seeded chains, raw seed words and four pacing patterns.");
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
